// ===== sv/assert_macros.svh =====
// Assertion macros shared by the downsampler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside of reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
	else $error("assertion failed");

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
	else $error("forbidden condition seen");

`endif

// ===== sv/rmbd_pkg.sv =====
// Shared types and constants of the RGBA mipmap box downsampler.
// No dependencies; imported by every module of the block.
package rmbd_pkg;

	localparam int MAX_DIM_DEF    = 2048;
	localparam int MAX_LEVELS_DEF = 12;
	localparam int CFG_W          = 12;

	// register indexes on the configuration port
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// one RGBA8 pixel, red in lane 0 up to alpha in lane 3
	typedef logic [3:0][7:0] pix_t;

	// four 9-bit horizontal pair sums
	typedef logic [3:0][8:0] pair_t;

	typedef struct packed {
		logic [3:0]  level;
		logic [10:0] x;
		logic [10:0] y;
		pix_t        pix;
		logic        run_end;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EMIT,
		B_READ
	} back_state_t;

endpackage

// ===== sv/rmbd_front.sv =====
// Front part: accepts level-zero pixels into a two-entry queue.
// Depends on rmbd_pkg.
module rmbd_front import rmbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  pix_t       in_pix,
	output logic       q_valid,
	output pix_t       q_pix,
	input  logic       q_pop,
	output fifo_stat_t stat
);

	pix_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign in_ready   = !stat.full;
	assign q_valid    = !stat.empty;
	assign q_pix      = buf_q[rd_ptr_q];
	assign push       = in_valid && in_ready;
	assign pop        = q_pop && q_valid;

	// store accepted beats
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_pix;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== sv/rmbd_back.sv =====
// Back part: walks the mip levels of one pixel, one level per step,
// with the pair-sum line memory. Depends on rmbd_pkg.
module rmbd_back import rmbd_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int MAX_LEVELS = MAX_LEVELS_DEF,
	localparam int AW = $clog2(MAX_DIM),
	localparam int DW = AW + 1,
	localparam int KW = $clog2(MAX_LEVELS),
	localparam int LW = $clog2(MAX_LEVELS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [DW-1:0] dim_w,
	input  logic [DW-1:0] dim_h,
	input  logic [LW-1:0] levels,
	input  logic          restart,
	input  logic          q_valid,
	input  pix_t          q_pix,
	output logic          q_pop,
	output res_t          res,
	output logic          res_valid,
	input  logic          res_ready
);

	back_state_t   state_q, state_d;
	logic [KW-1:0] k_q;
	logic [DW-1:0] w_q;
	logic [DW-1:0] h_q;
	pix_t          pix_q;
	pair_t         pair_s1;
	logic [AW-1:0] col_q [MAX_LEVELS];
	logic [AW-1:0] row_q [MAX_LEVELS];
	pix_t          hold_q [MAX_LEVELS];
	logic [35:0]   mem [MAX_DIM];
	logic [35:0]   mem_q;
	res_t          res_q;
	logic          ov_q;

	logic          can_out;
	logic [AW-1:0] x, y;
	logic [DW-1:0] dw, dh;
	logic          w1, h1;
	pair_t         pair;
	pair_t         top;
	pix_t          avg;
	logic          last;
	logic          emit;
	logic          load;
	logic          step;
	logic          mem_we, mem_re, hold_we;
	logic [AW:0]   idx_full;
	logic [AW-1:0] idx;
	logic [DW-1:0] x1, y1;

	assign can_out   = !ov_q || res_ready;
	assign x         = col_q[k_q];
	assign y         = row_q[k_q];
	assign w1        = (w_q == DW'(1));
	assign h1        = (h_q == DW'(1));
	assign dw        = (w_q[DW-1:1] == '0) ? DW'(1) : (w_q >> 1);
	assign dh        = (h_q[DW-1:1] == '0) ? DW'(1) : (h_q >> 1);
	assign x1        = DW'(x) + DW'(1);
	assign y1        = DW'(y) + DW'(1);
	assign res       = res_q;
	assign res_valid = ov_q;

	// horizontal pair of this level
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			pair[c] = w1 ? {pix_q[c], 1'b0} : (9'(hold_q[k_q][c]) + 9'(pix_q[c]));
		end
	end

	// line memory slot of this level's pair column
	always_comb begin
		idx_full = (AW+1)'(MAX_DIM) - ((AW+1)'(MAX_DIM) >> k_q) + (AW+1)'(x >> 1);
		idx = (idx_full >= (AW+1)'(MAX_DIM)) ? AW'(MAX_DIM - 1) : idx_full[AW-1:0];
	end

	// vertical combine of the stored upper pair and the held lower pair
	always_comb begin
		top = mem_q;
		for (int c = 0; c < 4; c++) begin
			avg[c] = 8'((10'(top[c]) + 10'(pair_s1[c])) >> 2);
		end
	end

	// sequence the levels of one pixel
	always_comb begin
		state_d = state_q;
		emit    = 1'b0;
		load    = 1'b0;
		step    = 1'b0;
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		hold_we = 1'b0;
		last    = (LW'(k_q) + LW'(1) >= levels)
			|| (!w1 && ((DW+1)'(x) >= (DW+1)'({dw, 1'b0}) || !x[0]))
			|| (!h1 && ((DW+1)'(y) >= (DW+1)'({dh, 1'b0}) || !y[0]));
		case (state_q)
			B_IDLE: begin
				load = q_valid;
				if (q_valid) state_d = B_EMIT;
			end
			B_EMIT: begin
				if (can_out) begin
					emit = 1'b1;
					hold_we = (LW'(k_q) + LW'(1) < levels) && !w1
						&& ((DW+1)'(x) < (DW+1)'({dw, 1'b0})) && !x[0];
					mem_we = (LW'(k_q) + LW'(1) < levels) && !h1 && (w1 || x[0])
						&& ((DW+1)'(x) < (DW+1)'({dw, 1'b0}) || w1)
						&& ((DW+1)'(y) < (DW+1)'({dh, 1'b0})) && !y[0];
					if (last) begin
						load    = q_valid;
						state_d = q_valid ? B_EMIT : B_IDLE;
					end else if (h1) begin
						step = 1'b1;
					end else begin
						mem_re  = 1'b1;
						state_d = B_READ;
					end
				end
			end
			B_READ: begin
				step    = 1'b1;
				state_d = B_EMIT;
			end
			default: state_d = B_IDLE;
		endcase
	end

	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)          ov_q <= 1'b1;
			else if (res_ready) ov_q <= 1'b0;
		end
	end

	// per-level position counters, cleared on a size change
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else if (restart) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else if (emit) begin
			if (x1 >= w_q) begin
				col_q[k_q] <= '0;
				row_q[k_q] <= (y1 >= h_q) ? '0 : y1[AW-1:0];
			end else begin
				col_q[k_q] <= x1[AW-1:0];
			end
		end
	end

	// level walk datapath
	always_ff @(posedge clk) begin
		if (load) begin
			pix_q <= q_pix;
			k_q   <= '0;
			w_q   <= dim_w;
			h_q   <= dim_h;
		end else if (step) begin
			k_q <= k_q + KW'(1);
			w_q <= dw;
			h_q <= dh;
			if (state_q == B_READ) begin
				pix_q <= avg;
			end else begin
				for (int c = 0; c < 4; c++) pix_q[c] <= pair[c][8:1];
			end
		end
		if (mem_re) pair_s1 <= pair;
		if (hold_we) hold_q[k_q] <= pix_q;
		if (emit) begin
			res_q.level   <= 4'(k_q);
			res_q.x       <= 11'(x);
			res_q.y       <= 11'(y);
			res_q.pix     <= pix_q;
			res_q.run_end <= last;
		end
	end

	// pair-sum line memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[idx] <= pair;
		if (mem_re) mem_q <= mem[idx];
	end

endmodule

// ===== sv/rgba_mipmap_box_downsampler.sv =====
// RGBA mipmap box downsampler. Each pixel yields one result per level it reaches:
// the level walk emits each level from its emit state and, while the height is above
// one, passes through a read state of the pair-sum line memory before the next level.
// An accepted pixel passes through the queue, the pixel register and the output register.
// Reset clears queue, level counters and sizes (1x1); line memory is left undefined.
module rgba_mipmap_box_downsampler import rmbd_pkg::*; #(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	input  logic [7:0]  alpha_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  mip_level,
	output logic [10:0] pos_x,
	output logic [10:0] pos_y,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [7:0]  alpha_out,
	output logic        run_end
);

	`include "assert_macros.svh"

	localparam int AW = $clog2(MAX_DIM);
	localparam int DW = AW + 1;
	localparam int EW = (DW > CFG_W) ? DW : CFG_W;
	localparam int LW = $clog2(MAX_LEVELS + 1);

	logic [CFG_W-1:0] width_q, height_q;
	logic             restart;
	logic             wr;
	logic [DW-1:0]    dim_w, dim_h, dim_m;
	logic [LW-1:0]    levels;
	pix_t             in_pix, q_pix;
	logic             q_valid, q_pop;
	fifo_stat_t       fstat;
	res_t             res;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign restart = wr;
	assign prdata  = 32'((paddr[2] == REG_HEIGHT) ? height_q : width_q);

	// hold size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(1);
			height_q <= CFG_W'(1);
		end else if (wr) begin
			if (paddr[2] == REG_WIDTH) width_q  <= pwdata[CFG_W-1:0];
			else                       height_q <= pwdata[CFG_W-1:0];
		end
	end

	function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [EW-1:0] e;
		e = EW'(v);
		if (e == '0) return DW'(1);
		if (e > EW'(MAX_DIM)) return DW'(MAX_DIM);
		return e[DW-1:0];
	endfunction

	// effective sizes and level count
	always_comb begin
		dim_w  = eff_dim(width_q);
		dim_h  = eff_dim(height_q);
		dim_m  = (dim_w > dim_h) ? dim_w : dim_h;
		levels = '0;
		for (int i = 0; i < DW; i++) begin
			if (dim_m[i]) levels = LW'(i + 1);
		end
		if (levels > LW'(MAX_LEVELS)) levels = LW'(MAX_LEVELS);
	end

	assign in_pix = {alpha_in, blue_in, green_in, red_in};

	rmbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_pix   (in_pix),
		.q_valid  (q_valid),
		.q_pix    (q_pix),
		.q_pop    (q_pop),
		.stat     (fstat)
	);

	rmbd_back #(
		.MAX_DIM    (MAX_DIM),
		.MAX_LEVELS (MAX_LEVELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dim_w     (dim_w),
		.dim_h     (dim_h),
		.levels    (levels),
		.restart   (restart),
		.q_valid   (q_valid),
		.q_pix     (q_pix),
		.q_pop     (q_pop),
		.res       (res),
		.res_valid (out_valid),
		.res_ready (out_ready)
	);

	assign mip_level = res.level;
	assign pos_x     = res.x;
	assign pos_y     = res.y;
	assign red_out   = res.pix[0];
	assign green_out = res.pix[1];
	assign blue_out  = res.pix[2];
	assign alpha_out = res.pix[3];
	assign run_end   = res.run_end;

	`ASSERT_AT(a_levels_nonzero, clk, arst_n, levels != '0)
	`ASSERT_NEVER(a_fifo_full_empty, clk, arst_n, fstat.full && fstat.empty)
	`ASSERT_AT(a_ready_tracks_fill, clk, arst_n, in_ready == !fstat.full)

endmodule
